// ----- src/sec_pkg.sv -----
// shared types and codes for the session expiry cache
package sec_pkg;
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_GET    = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_PRESENT = 2'd3;

    localparam logic CFG_ITEM_LIMIT = 1'b0;
    localparam logic CFG_LIFETIME   = 1'b1;

    typedef logic [1:0]  func_t;
    typedef logic [1:0]  status_t;
    typedef logic [31:0] key_t;
    typedef logic [15:0] handle_t;
    typedef logic [31:0] time_t;
    typedef logic [6:0]  count_t;
endpackage

// ----- src/sec_ram.sv -----
// generic single-port ram with registered read
module sec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- src/session_expiry_cache.sv -----
// top level of the session expiry cache: sequencer, tables and result register
//
// channel  direction  handshake          payload
// s_       in         s_valid/s_ready    func, session_key, session_handle, now_seconds
// m_       out        m_valid/m_ready    status, handle_out, entry_count, swept_count
// cfg      in         cfg_we             cfg_index, cfg_wdata
//
// one transaction walks the single-port entry ram slot by slot: address, then check
// of the read data; add, remove and get scan every slot, an add with sweep first
// sweeps every slot and stops there if the table stays full, and a dropped add with
// the sweep skipped or an unused operation code goes straight to the result state.
// s_ready is low from acceptance until the result is loaded into the m_ register;
// a result still waiting on m_ready holds the sequencer in its last state
// synchronous active-low reset clears valid bits, live count and oldest time
module session_expiry_cache #(
    parameter int CAPACITY = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [31:0]             cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  sec_pkg::func_t          s_func,
    input  sec_pkg::key_t           s_session_key,
    input  sec_pkg::handle_t        s_session_handle,
    input  sec_pkg::time_t          s_now_seconds,
    output logic                    m_valid,
    input  logic                    m_ready,
    output sec_pkg::status_t        m_status,
    output sec_pkg::handle_t        m_handle_out,
    output logic [$clog2(CAPACITY+1)-1:0] m_entry_count,
    output logic [$clog2(CAPACITY+1)-1:0] m_swept_count
);
    import sec_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam int RW = 32 + 16 + 32;
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1; // address issued, waiting for read data
    localparam logic [2:0] S_SWCHK = 3'd2; // data back, check entry
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SCHK  = 3'd4;
    localparam logic [2:0] S_DEC   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [5:0] limit_reg;
    time_t      life_reg;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CW-1:0] live_reg, live_next;
    time_t oldest_reg, oldest_next;

    // transaction held during work
    func_t   func_reg;
    key_t    key_reg;
    handle_t hnd_reg;
    time_t   now_reg;
    time_t   bound_reg, bound_next;
    time_t   least_reg, least_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] swept_reg, swept_next;
    logic hit_reg, hit_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic free_reg, free_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;

    // working status and handle, result valid
    status_t st_reg, st_next;
    handle_t ho_reg, ho_next;
    logic mv_reg, mv_next;

    // result register, keeps m_ stable while the next transaction runs
    status_t       res_st_reg, res_st_next;
    handle_t       res_ho_reg, res_ho_next;
    logic [CW-1:0] res_cnt_reg, res_cnt_next;
    logic [CW-1:0] res_sw_reg, res_sw_next;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [RW-1:0] ram_wdata, ram_rdata;
    key_t    rd_key;
    handle_t rd_hnd;
    time_t   rd_time;

    assign {rd_key, rd_hnd, rd_time} = ram_rdata;

    sec_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = mv_reg;
    assign m_status      = res_st_reg;
    assign m_handle_out  = res_ho_reg;
    assign m_entry_count = res_cnt_reg;
    assign m_swept_count = res_sw_reg;

    logic over_limit;
    assign over_limit = live_reg > CW'(limit_reg);

    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        live_next     = live_reg;
        oldest_next   = oldest_reg;
        bound_next    = bound_reg;
        least_next    = least_reg;
        idx_next      = idx_reg;
        swept_next    = swept_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        st_next       = st_reg;
        ho_next       = ho_reg;
        mv_next       = mv_reg;
        res_st_next   = res_st_reg;
        res_ho_next   = res_ho_reg;
        res_cnt_next  = res_cnt_reg;
        res_sw_next   = res_sw_reg;
        ram_we        = 1'b0;
        ram_addr      = idx_reg;
        ram_wdata     = {key_reg, hnd_reg, now_reg};

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    idx_next   = '0;
                    swept_next = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    st_next    = ST_DONE;
                    ho_next    = '0;
                    // saturating bound, skip sweep when oldest already at or past it
                    bound_next = (s_now_seconds >= life_reg) ?
                                 s_now_seconds - life_reg : '0;
                    least_next = s_now_seconds;
                    if (s_func == FUNC_ADD && over_limit &&
                        !(oldest_reg >= bound_next)) begin
                        state_next = S_SWEEP;
                    end else if (s_func == FUNC_ADD && over_limit) begin
                        st_next    = ST_FULL;
                        state_next = S_OUT;
                    end else if (s_func == FUNC_ADD || s_func == FUNC_REMOVE ||
                                 s_func == FUNC_GET) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_SWEEP: begin
                state_next = S_SWCHK;
            end
            S_SWCHK: begin
                if (valid_reg[idx_reg]) begin
                    if (rd_time < least_reg) begin
                        least_next = rd_time;
                    end
                    if (rd_time < bound_reg) begin
                        valid_next[idx_reg] = 1'b0;
                        live_next  = live_next - 1'b1;
                        swept_next = swept_reg + 1'b1;
                    end
                end
                if (idx_reg == LAST) begin
                    oldest_next = least_next;
                    idx_next    = '0;
                    if (live_next > CW'(limit_reg)) begin
                        st_next    = ST_FULL;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SWEEP;
                end
            end
            S_SCAN: begin
                state_next = S_SCHK;
            end
            S_SCHK: begin
                if (valid_reg[idx_reg] && rd_key == key_reg && !hit_reg) begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                    ho_next      = rd_hnd;
                end
                if (!valid_reg[idx_reg] && !free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (idx_reg == LAST) begin
                    state_next = S_DEC;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_DEC: begin
                state_next = S_OUT;
                case (func_reg)
                    FUNC_ADD: begin
                        ho_next = '0;
                        if (hit_reg) begin
                            st_next = ST_PRESENT;
                        end else if (!free_reg) begin
                            st_next = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_addr  = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            live_next = live_reg + 1'b1;
                        end
                    end
                    FUNC_REMOVE: begin
                        ho_next = '0;
                        if (hit_reg) begin
                            valid_next[hit_idx_reg] = 1'b0;
                            live_next = live_reg - 1'b1;
                        end
                    end
                    FUNC_GET: begin
                        if (hit_reg) begin
                            // refresh time, keep key and handle
                            ram_we    = 1'b1;
                            ram_addr  = hit_idx_reg;
                            ram_wdata = {key_reg, ho_reg, now_reg};
                        end else begin
                            st_next = ST_MISS;
                            ho_next = '0;
                        end
                    end
                    default: begin
                        ho_next = '0;
                    end
                endcase
            end
            S_OUT: begin
                // wait here while an earlier result is still not taken
                if (!mv_reg || m_ready) begin
                    mv_next      = 1'b1;
                    res_st_next  = st_reg;
                    res_ho_next  = ho_reg;
                    res_cnt_next = live_reg;
                    res_sw_next  = swept_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            live_reg   <= '0;
            oldest_reg <= '0;
            mv_reg     <= 1'b0;
            limit_reg  <= 6'd63;
            life_reg   <= 32'd3600;
        end else begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            live_reg   <= live_next;
            oldest_reg <= oldest_next;
            mv_reg     <= mv_next;
            if (cfg_we && cfg_index == CFG_ITEM_LIMIT) begin
                limit_reg <= cfg_wdata[5:0];
            end
            if (cfg_we && cfg_index == CFG_LIFETIME) begin
                life_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            key_reg  <= s_session_key;
            hnd_reg  <= s_session_handle;
            now_reg  <= s_now_seconds;
        end
        bound_reg    <= bound_next;
        least_reg    <= least_next;
        idx_reg      <= idx_next;
        swept_reg    <= swept_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        st_reg       <= st_next;
        ho_reg       <= ho_next;
        res_st_reg   <= res_st_next;
        res_ho_reg   <= res_ho_next;
        res_cnt_reg  <= res_cnt_next;
        res_sw_reg   <= res_sw_next;
    end
endmodule

// ----- sim/session_expiry_cache_tb.sv -----
// session expiry cache tb: directed and random add, remove and get traffic checked by a scoreboard
module session_expiry_cache_tb;
    import sec_pkg::*;

    localparam int SLOTS = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int IDLE_CYCLES = 4 * SLOTS + 20;

    typedef struct packed {
        status_t status;
        handle_t handle_out;
        count_t  entry_count;
        count_t  swept_count;
    } outcome_t;

    // scoreboard: a cycle-free copy of the table and a queue of expected outcomes
    class session_scoreboard;
        key_t      keys[SLOTS];
        handle_t   handles[SLOTS];
        time_t     stamps[SLOTS];
        bit        occupied[SLOTS];
        int        live;
        time_t     oldest;
        bit [5:0]  limit;
        time_t     lifetime;
        outcome_t  pending[$];
        int        errors;
        int        checked;
        int        n_swept;
        int        n_full;
        int        n_hit;

        function void clear();
            foreach (occupied[i]) occupied[i] = 0;
            live = 0;
            oldest = 0;
            limit = 63;
            lifetime = 3600;
        endfunction

        function int find(key_t k);
            foreach (occupied[i])
                if (occupied[i] && keys[i] == k) return i;
            return -1;
        endfunction

        // expiry pass ahead of an add
        function int expire(time_t now);
            time_t bound;
            time_t least;
            int    gone;
            bound = (now >= lifetime) ? now - lifetime : 0;
            least = now;
            gone = 0;
            if (oldest >= bound) return 0;
            foreach (occupied[i]) begin
                if (!occupied[i]) continue;
                if (stamps[i] < least) least = stamps[i];
                if (stamps[i] < bound) begin
                    occupied[i] = 0;
                    live--;
                    gone++;
                end
            end
            oldest = least;
            return gone;
        endfunction

        function void note_request(func_t f, key_t k, handle_t h, time_t now);
            outcome_t o;
            int       s;
            o = '0;
            if (f == FUNC_ADD) begin
                if (live > limit) o.swept_count = count_t'(expire(now));
                if (live > limit) begin
                    o.status = ST_FULL;
                end else if (find(k) >= 0) begin
                    o.status = ST_PRESENT;
                end else begin
                    s = -1;
                    foreach (occupied[i])
                        if (!occupied[i] && s < 0) s = i;
                    if (s < 0) begin
                        o.status = ST_FULL;
                    end else begin
                        occupied[s] = 1;
                        keys[s] = k;
                        handles[s] = h;
                        stamps[s] = now;
                        live++;
                    end
                end
                if (o.status == ST_FULL) n_full++;
                if (o.swept_count != 0) n_swept++;
            end else if (f == FUNC_REMOVE) begin
                s = find(k);
                if (s >= 0) begin
                    occupied[s] = 0;
                    live--;
                end
            end else if (f == FUNC_GET) begin
                s = find(k);
                if (s >= 0) begin
                    stamps[s] = now;
                    o.handle_out = handles[s];
                    n_hit++;
                end else begin
                    o.status = ST_MISS;
                end
            end
            o.entry_count = count_t'(live);
            pending.push_back(o);
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (pending.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status != want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.handle_out != want.handle_out) begin
                $error("handle_out expected %0h actual %0h", want.handle_out, got.handle_out);
                errors++;
            end
            if (got.entry_count != want.entry_count) begin
                $error("entry_count expected %0d actual %0d", want.entry_count,
                       got.entry_count);
                errors++;
            end
            if (got.swept_count != want.swept_count) begin
                $error("swept_count expected %0d actual %0d", want.swept_count,
                       got.swept_count);
                errors++;
            end
        endfunction
    endclass

    logic     aclk = 0;
    logic     aresetn = 0;
    logic     cfg_we = 0;
    logic     cfg_index = CFG_ITEM_LIMIT;
    logic [31:0] cfg_wdata = '0;
    logic     s_valid = 0;
    logic     s_ready;
    func_t    s_func = FUNC_ADD;
    key_t     s_session_key = '0;
    handle_t  s_session_handle = '0;
    time_t    s_now_seconds = '0;
    logic     m_valid;
    logic     m_ready = 0;
    status_t  m_status;
    handle_t  m_handle_out;
    logic [6:0] m_entry_count;
    logic [6:0] m_swept_count;

    session_scoreboard sb;
    time_t  clock_now;        // advancing time base for the stimulus
    key_t   key_pool[16];     // small key set so gets and removes hit often
    bit     hold_off = 0;     // long receiver stall requested
    bit     traffic_done = 0;
    int     idle_run = 0;
    int     sent = 0;

    always #1 aclk = ~aclk;

    session_expiry_cache #(.CAPACITY(SLOTS)) i_dut (.*);

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 4);
    endfunction

    // write enable drops again after each write
    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 0;
        if (idx == CFG_ITEM_LIMIT) sb.limit = val[5:0];
        else sb.lifetime = val;
        @(posedge aclk);
    endtask

    // one request transaction, with an optional leading gap; valid stays up
    // after acceptance until the next gap or drain
    task automatic send_request(func_t f, key_t k, handle_t h, time_t now, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g != 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_valid          <= 1;
        s_func           <= f;
        s_session_key    <= k;
        s_session_handle <= h;
        s_now_seconds    <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(f, k, h, now);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_request(bit gaps);
        func_t   f;
        key_t    k;
        int      r;
        r = $urandom_range(0, 99);
        f = (r < 45) ? FUNC_ADD : (r < 65) ? FUNC_REMOVE : (r < 97) ? FUNC_GET : FUNC_NONE;
        k = ($urandom_range(0, 4) == 0) ? key_t'($urandom) : key_pool[$urandom_range(0, 15)];
        // time mostly creeps forward, sometimes jumps or wanders back
        r = $urandom_range(0, 99);
        if (r < 80) clock_now += $urandom_range(0, 40);
        else if (r < 95) clock_now += $urandom_range(100, 5000);
        else clock_now = $urandom;
        send_request(f, k, handle_t'($urandom), clock_now, gaps);
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            g = pick_gap();
            if (g != 0) begin
                m_ready <= 0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
        end
    end

    // sample results at the clock edge on which they are taken
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_status, m_handle_out, m_entry_count, m_swept_count});
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_run <= 0;
        else idle_run <= idle_run + 1;
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("session_expiry_cache test failed");
            $finish;
        end
    end

    initial begin
        sb = new();
        sb.clear();
        clock_now = 5000;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: field extremes, every operation, corner cases
        send_request(FUNC_GET, 32'h0, 16'h0, 32'd0, 0);             // miss on empty
        send_request(FUNC_ADD, 32'h0, 16'hffff, 32'd100, 0);
        send_request(FUNC_ADD, 32'hffffffff, 16'h0, 32'hffffffff, 0);
        send_request(FUNC_ADD, 32'h0, 16'h1234, 32'd200, 0);        // key already present
        send_request(FUNC_GET, 32'hffffffff, 16'h5555, 32'd300, 0);
        send_request(FUNC_GET, 32'h0, 16'h0, 32'd400, 0);
        send_request(FUNC_REMOVE, 32'h12345678, 16'h0, 32'd400, 0); // remove absent key
        send_request(FUNC_REMOVE, 32'hffffffff, 16'h0, 32'd400, 0);
        send_request(FUNC_NONE, 32'h0, 16'hffff, 32'd400, 0);       // unused code
        send_request(FUNC_GET, 32'hffffffff, 16'h0, 32'd500, 0);    // miss after remove
        drain();
        // tiny limit: bound below zero skips sweep, then full drop even for present key
        write_reg(CFG_ITEM_LIMIT, 32'd1);
        write_reg(CFG_LIFETIME, 32'hffffffff);
        send_request(FUNC_ADD, 32'd7, 16'd7, 32'd600, 0);
        send_request(FUNC_ADD, 32'd8, 16'd8, 32'd700, 0);
        send_request(FUNC_ADD, 32'd0, 16'd9, 32'd800, 0);
        drain();
        // zero lifetime: every older entry is swept
        write_reg(CFG_LIFETIME, 32'd0);
        send_request(FUNC_ADD, 32'd9, 16'd9, 32'd900, 0);
        send_request(FUNC_ADD, 32'd10, 16'd10, 32'd900, 0);
        send_request(FUNC_ADD, 32'd11, 16'd11, 32'd901, 0);
        drain();
        // highest limit, fill every slot and overflow
        write_reg(CFG_ITEM_LIMIT, 32'd63);
        write_reg(CFG_LIFETIME, 32'd3600);
        hold_off = 1;     // receiver stalls while the table fills
        for (int i = 0; i < 70; i++)
            send_request(FUNC_ADD, key_t'(32'h1000 + i), handle_t'(i), 32'd1000 + i, 0);
        drain();
        send_request(FUNC_ADD, 32'h9999, 16'h1, 32'd20000, 0);     // sweep frees slots
        drain();

        // random phases over several settings
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin write_reg(CFG_ITEM_LIMIT, 32'd4);  write_reg(CFG_LIFETIME, 32'd50); end
                1: begin write_reg(CFG_ITEM_LIMIT, 32'd63); write_reg(CFG_LIFETIME, 32'd200); end
                2: begin write_reg(CFG_ITEM_LIMIT, 32'd10); write_reg(CFG_LIFETIME, 32'd0); end
                3: begin write_reg(CFG_ITEM_LIMIT, 32'd1);  write_reg(CFG_LIFETIME, 32'hffffffff); end
                4: begin write_reg(CFG_ITEM_LIMIT, $urandom_range(1, 63));
                         write_reg(CFG_LIFETIME, $urandom_range(0, 3000)); end
                default: begin write_reg(CFG_ITEM_LIMIT, 32'd20); write_reg(CFG_LIFETIME, 32'd3600); end
            endcase
            for (int n = 0; n < 280; n++) random_request(n % 100 > 20);
            drain();
        end

        traffic_done = 1;
        $display("covered %0d requests, %0d results checked: %0d get hits, %0d sweeps, %0d drops",
                 sent, sb.checked, sb.n_hit, sb.n_swept, sb.n_full);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("session_expiry_cache test passed");
        end else begin
            $display("session_expiry_cache test failed");
        end
        $finish;
    end
endmodule
